// ===== hw/rtl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, constants and codes of the keypad code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  // Number of keys in one code.
  localparam int unsigned CODE_LENGTH = 4;
  localparam int unsigned IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned MATCH_W     = $clog2(CODE_LENGTH + 1);

  localparam int unsigned TICK_W      = 16;
  localparam int unsigned TRIES_W     = 3;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned MSG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;

  // Input request kinds.
  localparam logic [ACTION_W-1:0] ACT_KEY  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EXIT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTICE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHOICE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES     = 3'd4;

  localparam logic [TICK_W-1:0]  DOOR_TICKS_RST    = 16'd3000;
  localparam logic [TICK_W-1:0]  LOCKOUT_TICKS_RST = 16'd5000;
  localparam logic [TICK_W-1:0]  NOTICE_TICKS_RST  = 16'd2000;
  localparam logic [TICK_W-1:0]  CHOICE_TICKS_RST  = 16'd100;
  localparam logic [TRIES_W-1:0] MAX_TRIES_RST     = 3'd3;

  // Menu keys and the first digit of the factory code.
  localparam logic [KEY_W-1:0] KEY_PLUS   = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_MINUS  = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_DIGIT1 = 8'h31;

  // Message codes shown on the display.
  localparam logic [MSG_W-1:0] MSG_PROMPT   = 4'd0;
  localparam logic [MSG_W-1:0] MSG_MENU     = 4'd1;
  localparam logic [MSG_W-1:0] MSG_NEW      = 4'd2;
  localparam logic [MSG_W-1:0] MSG_AGAIN    = 4'd3;
  localparam logic [MSG_W-1:0] MSG_WELCOME  = 4'd4;
  localparam logic [MSG_W-1:0] MSG_RETRY    = 4'd5;
  localparam logic [MSG_W-1:0] MSG_LOCKOUT  = 4'd6;
  localparam logic [MSG_W-1:0] MSG_SAVED    = 4'd7;
  localparam logic [MSG_W-1:0] MSG_MISMATCH = 4'd8;
  localparam logic [MSG_W-1:0] MSG_BAD      = 4'd9;

  typedef struct packed {
    logic [TICK_W-1:0]  door_ticks;
    logic [TICK_W-1:0]  lockout_ticks;
    logic [TICK_W-1:0]  notice_ticks;
    logic [TICK_W-1:0]  choice_ticks;
    logic [TRIES_W-1:0] max_tries;
  } cfg_t;

  typedef struct packed {
    logic             door_open;
    logic             alarm_on;
    logic [MSG_W-1:0] message;
    logic             echo_star;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kcl_cfg.sv =====
// ----------------------------------------------------------------------------
// kcl_cfg
// Configuration register file: timer lengths and the attempt limit.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0] index_i,
  input  wire logic [kcl_pkg::TICK_W-1:0]    data_i,
  output kcl_pkg::cfg_t                      cfg_o
);
  import kcl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        REG_DOOR_TICKS:    cfg_d.door_ticks    = data_i;
        REG_LOCKOUT_TICKS: cfg_d.lockout_ticks = data_i;
        REG_NOTICE_TICKS:  cfg_d.notice_ticks  = data_i;
        REG_CHOICE_TICKS:  cfg_d.choice_ticks  = data_i;
        REG_MAX_TRIES:     cfg_d.max_tries     = data_i[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.door_ticks    <= DOOR_TICKS_RST;
      cfg_q.lockout_ticks <= LOCKOUT_TICKS_RST;
      cfg_q.notice_ticks  <= NOTICE_TICKS_RST;
      cfg_q.choice_ticks  <= CHOICE_TICKS_RST;
      cfg_q.max_tries     <= MAX_TRIES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/kcl_core.sv =====
// ----------------------------------------------------------------------------
// kcl_core
// Lock state machine: code entry, menu, code change and timed phases.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [kcl_pkg::ACTION_W-1:0] action_i,
  input  wire logic [kcl_pkg::KEY_W-1:0]    key_i,
  input  wire kcl_pkg::cfg_t                cfg_i,
  output kcl_pkg::res_t                     res_o
);
  import kcl_pkg::*;

  typedef enum logic [3:0] {
    M_PROMPT, M_MENU, M_NEW, M_AGAIN, M_DOOR, M_DOOREXIT,
    M_RETRY, M_LOCKOUT, M_SAVED, M_MISMATCH, M_BAD
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic [TRIES_W-1:0] tries_q, tries_d;
  logic [TICK_W-1:0]  wait_q, wait_d;
  logic [KEY_W-1:0]   stored_q [CODE_LENGTH];
  logic [KEY_W-1:0]   new_q    [CODE_LENGTH];

  logic               new_we, save;
  logic               echo;
  logic               last_digit, hit, full;
  logic [MATCH_W-1:0] match_inc;
  logic [TRIES_W-1:0] tries_inc;
  logic [KEY_W-1:0]   ref_key;
  logic               timed;

  assign timed      = (mode_q >= M_DOOR);
  assign last_digit = (idx_q == IDX_W'(CODE_LENGTH - 1));
  assign ref_key    = (mode_q == M_AGAIN) ? new_q[idx_q] : stored_q[idx_q];
  assign hit        = (key_i == ref_key);
  assign match_inc  = match_q + MATCH_W'(hit);
  assign full       = (match_inc == MATCH_W'(CODE_LENGTH));
  assign tries_inc  = tries_q + TRIES_W'(1);

  always_comb begin
    mode_d  = mode_q;
    idx_d   = idx_q;
    match_d = match_q;
    tries_d = tries_q;
    wait_d  = wait_q;
    new_we  = 1'b0;
    save    = 1'b0;
    echo    = 1'b0;

    unique case (action_i)
      ACT_KEY: begin
        unique case (mode_q)
          M_PROMPT: begin
            echo    = 1'b1;
            idx_d   = idx_q + IDX_W'(1);
            match_d = match_inc;
            if (last_digit) begin
              idx_d   = '0;
              match_d = '0;
              if (full) begin
                tries_d = '0;
                mode_d  = M_MENU;
              end else if (tries_inc >= cfg_i.max_tries) begin
                tries_d = '0;
                mode_d  = M_LOCKOUT;
                wait_d  = cfg_i.lockout_ticks;
              end else begin
                tries_d = tries_inc;
                mode_d  = M_RETRY;
                wait_d  = cfg_i.notice_ticks;
              end
            end
          end
          M_MENU: begin
            if (key_i == KEY_PLUS) begin
              mode_d = M_DOOR;
              wait_d = cfg_i.door_ticks;
            end else if (key_i == KEY_MINUS) begin
              mode_d  = M_NEW;
              idx_d   = '0;
              match_d = '0;
            end else begin
              mode_d = M_BAD;
              wait_d = cfg_i.choice_ticks;
            end
          end
          M_NEW: begin
            echo   = 1'b1;
            new_we = 1'b1;
            idx_d  = idx_q + IDX_W'(1);
            if (last_digit) begin
              mode_d  = M_AGAIN;
              idx_d   = '0;
              match_d = '0;
            end
          end
          M_AGAIN: begin
            echo    = 1'b1;
            idx_d   = idx_q + IDX_W'(1);
            match_d = match_inc;
            if (last_digit) begin
              idx_d   = '0;
              match_d = '0;
              wait_d  = cfg_i.notice_ticks;
              if (full) begin
                save   = 1'b1;
                mode_d = M_SAVED;
              end else begin
                mode_d = M_MISMATCH;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (timed) begin
          if (wait_q <= TICK_W'(1)) begin
            wait_d = '0;
            unique case (mode_q)
              M_DOOR, M_LOCKOUT, M_SAVED: begin
                tries_d = '0;
                mode_d  = M_PROMPT;
                idx_d   = '0;
                match_d = '0;
              end
              M_DOOREXIT, M_RETRY: begin
                mode_d  = M_PROMPT;
                idx_d   = '0;
                match_d = '0;
              end
              default: mode_d = M_MENU;
            endcase
          end else begin
            wait_d = wait_q - TICK_W'(1);
          end
        end
      end
      ACT_EXIT: begin
        // The exit button only works while no code entry has begun.
        if (mode_q == M_PROMPT && idx_q == '0) begin
          mode_d = M_DOOREXIT;
          wait_d = cfg_i.door_ticks;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.door_open = (mode_d == M_DOOR) || (mode_d == M_DOOREXIT);
    res_o.alarm_on  = (mode_d == M_LOCKOUT);
    res_o.echo_star = echo;
    unique case (mode_d)
      M_PROMPT:   res_o.message = MSG_PROMPT;
      M_MENU:     res_o.message = MSG_MENU;
      M_NEW:      res_o.message = MSG_NEW;
      M_AGAIN:    res_o.message = MSG_AGAIN;
      M_DOOR:     res_o.message = MSG_WELCOME;
      M_DOOREXIT: res_o.message = MSG_WELCOME;
      M_RETRY:    res_o.message = MSG_RETRY;
      M_LOCKOUT:  res_o.message = MSG_LOCKOUT;
      M_SAVED:    res_o.message = MSG_SAVED;
      M_MISMATCH: res_o.message = MSG_MISMATCH;
      M_BAD:      res_o.message = MSG_BAD;
      default:    res_o.message = MSG_PROMPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_PROMPT;
      idx_q   <= '0;
      match_q <= '0;
      tries_q <= '0;
      wait_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      idx_q   <= idx_d;
      match_q <= match_d;
      tries_q <= tries_d;
      wait_q  <= wait_d;
    end
  end

  // The stored code comes out of reset as the factory code, one digit up per place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= KEY_DIGIT1 + KEY_W'(i % 4);
      end
    end else if (step_i && save) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= new_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && new_we) begin
      new_q[idx_q] <= key_i;
    end
  end

`ifndef SYNTHESIS
  a_idx_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mode_q == M_PROMPT || mode_q == M_NEW || mode_q == M_AGAIN)
      |-> (idx_q == '0 && match_q == '0))
    else $error("digit position not cleared outside code entry");

  a_match_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    MATCH_W'(idx_q) >= match_q)
    else $error("match count exceeds digits entered");

  a_menu_plus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && mode_q == M_MENU && action_i == ACT_KEY && key_i == KEY_PLUS)
      |=> (mode_q == M_DOOR))
    else $error("plus key in menu did not open the door");

  a_echo_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.echo_star |-> (action_i == ACT_KEY &&
      (mode_q == M_PROMPT || mode_q == M_NEW || mode_q == M_AGAIN)))
    else $error("echo given outside code entry");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_code_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock: code entry with attempt limit, menu, code change, door.
// ----------------------------------------------------------------------------
// Each request (a key press, a timer tick or an exit-button press) is taken
// while in_ready_o is high, and its status result appears in the output
// register on the next cycle; one request per clock is sustained unless
// out_ready_i stalls, as the output register lets the next request in while
// the last result is being taken. Timed phases count ticks, not clocks.
// Configuration writes are taken on every cycle and should be made while idle.
`default_nettype none

module keypad_code_lock (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [kcl_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [kcl_pkg::KEY_W-1:0]     key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               door_open_o,
  output logic                               alarm_on_o,
  output logic [kcl_pkg::MSG_W-1:0]          message_o,
  output logic                               echo_star_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [kcl_pkg::TICK_W-1:0]    cfg_data_i
);
  import kcl_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic step;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  kcl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  kcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .action_i (action_i),
    .key_i    (key_i),
    .cfg_i    (cfg),
    .res_o    (res_next)
  );

  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign door_open_o = res_q.door_open;
  assign alarm_on_o  = res_q.alarm_on;
  assign message_o   = res_q.message;
  assign echo_star_o = res_q.echo_star;

endmodule

`default_nettype wire
